// ----- rtl/ictf_pkg.sv -----
// shared types, constants and the cordic angle table of the tilt filter
package ictf_pkg;

    localparam int ATAN_LEN   = 28;
    localparam int SQRT_ITERS = 24;
    localparam int ADDR_W     = 4;

    localparam logic [ADDR_W-1:0] ADDR_HIGH_GAIN = 4'd0;
    localparam logic [ADDR_W-1:0] ADDR_LOW_GAIN  = 4'd4;
    localparam logic [ADDR_W-1:0] ADDR_STEP_GAIN = 4'd8;

    localparam logic [16:0] HIGH_GAIN_RST = 17'd64225;
    localparam logic [16:0] LOW_GAIN_RST  = 17'd1311;
    localparam logic [23:0] STEP_GAIN_RST = 24'd5721;

    localparam logic signed [31:0] DEG_PER_RAD = 32'sd961263669;

    typedef struct packed {
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } t_sample;

    typedef struct packed {
        logic [16:0] high_gain;
        logic [16:0] low_gain;
        logic [23:0] step_gain;
    } t_cfg;

    function automatic logic signed [31:0] atan_q30(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:  v = 32'sh3243F6A8;
            5'd1:  v = 32'sh1DAC6705;
            5'd2:  v = 32'sh0FADBAFC;
            5'd3:  v = 32'sh07F56EA6;
            5'd4:  v = 32'sh03FEAB76;
            5'd5:  v = 32'sh01FFD55B;
            5'd6:  v = 32'sh00FFFAAA;
            5'd7:  v = 32'sh007FFF55;
            5'd8:  v = 32'sh003FFFEA;
            5'd9:  v = 32'sh001FFFFD;
            5'd10: v = 32'sh000FFFFF;
            5'd11: v = 32'sh0007FFFF;
            5'd12: v = 32'sh0003FFFF;
            5'd13: v = 32'sh0001FFFF;
            5'd14: v = 32'sh0000FFFF;
            5'd15: v = 32'sh00007FFF;
            5'd16: v = 32'sh00003FFF;
            5'd17: v = 32'sh00001FFF;
            5'd18: v = 32'sh00000FFF;
            5'd19: v = 32'sh000007FF;
            5'd20: v = 32'sh000003FF;
            5'd21: v = 32'sh000001FF;
            5'd22: v = 32'sh000000FF;
            5'd23: v = 32'sh0000007F;
            5'd24: v = 32'sh0000003F;
            5'd25: v = 32'sh0000001F;
            5'd26: v = 32'sh0000000F;
            5'd27: v = 32'sh00000007;
            default: v = 32'sh0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/ictf_front.sv -----
// input side: accepts samples into a two-entry queue ahead of the compute engine
module ictf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  ictf_pkg::t_sample i_sample,
    output logic              o_valid,
    output ictf_pkg::t_sample o_sample,
    input  logic              i_take
);
    import ictf_pkg::*;

    t_sample    r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       w_wr, w_rd;

    assign o_full   = (r_count == 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign o_sample = r_mem[r_rptr];
    assign w_wr     = i_push && !o_full;
    assign w_rd     = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_sample;
        end
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_wr) r_wptr <= !r_wptr;
            if (w_rd) r_rptr <= !r_rptr;
            r_count <= r_count + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

endmodule

// ----- rtl/ictf_back.sv -----
// compute engine: square root, cordic tilt, blend and degree conversion per axis
module ictf_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ictf_pkg::t_cfg     i_cfg,
    input  logic               i_valid,
    input  ictf_pkg::t_sample  i_sample,
    output logic               o_take,
    output logic               o_res_valid,
    input  logic               i_pop,
    output logic signed [31:0] o_roll_rad,
    output logic signed [31:0] o_pitch_rad,
    output logic signed [31:0] o_roll_deg,
    output logic signed [31:0] o_pitch_deg
);
    import ictf_pkg::*;

    localparam int STEPS_USED = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam logic [4:0] LAST_STEP = 5'(STEPS_USED - 1);
    localparam logic [4:0] LAST_SQRT = 5'(SQRT_ITERS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_SQRT, S_CORDIC, S_INC, S_PRED, S_PROD, S_SUM, S_DEG, S_DEGR,
        S_OUT
    } t_state;

    t_state             r_state;
    t_sample            r_smp;
    logic               r_axis;
    logic [4:0]         r_cnt;
    logic [47:0]        r_n, r_res, r_bit;
    logic signed [31:0] r_x, r_y, r_z;
    logic signed [41:0] r_inc;
    logic signed [41:0] r_pred;
    logic signed [59:0] r_p1;
    logic signed [44:0] r_p2;
    logic signed [63:0] r_degp;
    logic signed [31:0] r_roll, r_pitch, r_roll_deg;
    logic               r_out_valid;
    logic signed [31:0] r_o_roll, r_o_pitch, r_o_rdeg, r_o_pdeg;

    logic signed [15:0] w_num, w_p, w_q;
    logic signed [31:0] w_xs, w_ys, w_ang, w_cur;
    logic signed [25:0] w_tilt;
    logic signed [33:0] w_z_rnd;
    logic [47:0]        w_trial;
    logic signed [60:0] w_sum;
    logic signed [44:0] w_rs;
    logic signed [31:0] w_sat;
    logic signed [63:0] w_deg_rnd;
    logic signed [40:0] w_gprod;
    logic signed [15:0] w_gyro;
    logic               w_out_free;

    assign w_num   = r_axis ? r_smp.accel_x : r_smp.accel_y;
    assign w_p     = r_axis ? r_smp.accel_y : r_smp.accel_x;
    assign w_q     = r_smp.accel_z;
    assign w_gyro  = r_axis ? r_smp.gyro_y : r_smp.gyro_x;
    assign w_cur   = r_axis ? r_pitch : r_roll;
    assign w_xs    = r_x >>> r_cnt;
    assign w_ys    = r_y >>> r_cnt;
    assign w_ang   = atan_q30(r_cnt);
    assign w_trial = r_res + r_bit;
    assign w_z_rnd = 34'(r_z) + 34'sd32;
    assign w_tilt  = (w_num == 16'sd0) ? 26'sd0 : w_z_rnd[31:6];
    assign w_gprod = w_gyro * $signed({1'b0, i_cfg.step_gain});
    assign w_sum   = 61'(r_p1) + 61'(r_p2) + 61'sd32768;
    assign w_rs    = w_sum[60:16];
    assign w_sat   = (w_rs > 45'sd2147483647) ? 32'sh7FFFFFFF :
                     (w_rs < -45'sd2147483648) ? 32'sh80000000 : w_rs[31:0];
    assign w_deg_rnd  = r_degp + 64'sh80000000;
    assign w_out_free = !r_out_valid || i_pop;

    assign o_take      = (r_state == S_IDLE) && i_valid;
    assign o_res_valid = r_out_valid;
    assign o_roll_rad  = r_o_roll;
    assign o_pitch_rad = r_o_pitch;
    assign o_roll_deg  = r_o_rdeg;
    assign o_pitch_deg = r_o_pdeg;

    function automatic logic signed [31:0] r_degp_hold(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + 64'sh80000000;
        return t[63:32];
    endfunction

    function automatic logic [47:0] w_res_next(input logic [47:0] n, input logic [47:0] res,
                                               input logic [47:0] bt);
        logic [47:0] t;
        t = res + bt;
        return (n >= t) ? (res >> 1) + bt : (res >> 1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_roll      <= 32'sd0;
            r_pitch     <= 32'sd0;
            r_out_valid <= 1'b0;
            r_axis      <= 1'b0;
            r_cnt       <= 5'd0;
        end else begin
            if (i_pop && r_out_valid && r_state != S_OUT) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_smp   <= i_sample;
                        r_axis  <= 1'b0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_n     <= {(32'(w_p) * 32'(w_p) + 32'(w_q) * 32'(w_q)), 16'd0};
                    r_res   <= 48'd0;
                    r_bit   <= 48'd1 << 46;
                    r_cnt   <= 5'd0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_n >= w_trial) begin
                        r_n   <= r_n - w_trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_cnt == LAST_SQRT) begin
                        r_cnt   <= 5'd0;
                        r_state <= S_CORDIC;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                    if (r_cnt == 5'd0) begin
                        r_y <= 32'(w_num) <<< 8;
                        r_z <= 32'sd0;
                    end
                end
                S_CORDIC: begin
                    if (r_y >= 0) begin
                        r_x <= r_x + w_ys;
                        r_y <= r_y - w_xs;
                        r_z <= r_z + w_ang;
                    end else begin
                        r_x <= r_x - w_ys;
                        r_y <= r_y + w_xs;
                        r_z <= r_z - w_ang;
                    end
                    if (r_cnt == LAST_STEP) begin
                        r_state <= S_INC;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_INC: begin
                    r_inc   <= (42'(w_gprod) + 42'sd128) >>> 8;
                    r_state <= S_PRED;
                end
                S_PRED: begin
                    r_pred  <= 42'(w_cur) + r_inc;
                    r_state <= S_PROD;
                end
                S_PROD: begin
                    r_p1    <= $signed({1'b0, i_cfg.high_gain}) * r_pred;
                    r_p2    <= $signed({1'b0, i_cfg.low_gain}) * w_tilt;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (r_axis) r_pitch <= w_sat;
                    else        r_roll  <= w_sat;
                    r_state <= S_DEG;
                end
                S_DEG: begin
                    r_degp  <= w_cur * DEG_PER_RAD;
                    r_state <= S_DEGR;
                end
                S_DEGR: begin
                    if (r_axis) begin
                        r_state <= S_OUT;
                    end else begin
                        r_roll_deg <= w_deg_rnd[63:32];
                        r_axis     <= 1'b1;
                        r_state    <= S_SQ;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_o_roll    <= r_roll;
                        r_o_pitch   <= r_pitch;
                        r_o_rdeg    <= r_roll_deg;
                        r_o_pdeg    <= r_degp_hold(r_degp);
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_SQRT && r_cnt == LAST_SQRT) begin
                r_x <= 32'(w_res_next(r_n, r_res, r_bit));
            end
        end
    end

endmodule

// ----- rtl/imu_complementary_tilt_filter.sv -----
// top level: configuration registers, input queue and compute engine
// the shared sqrt/cordic unit handles both axes of one sample before it takes the next sample
// one result waits in the output register while the next sample is computed
// reset is synchronous, active low: angles clear to zero, gains take their defaults
module imu_complementary_tilt_filter #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [15:0]            i_gyro_x,
    input  logic signed [15:0]            i_gyro_y,
    input  logic signed [15:0]            i_accel_x,
    input  logic signed [15:0]            i_accel_y,
    input  logic signed [15:0]            i_accel_z,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [31:0]            o_roll_rad,
    output logic signed [31:0]            o_pitch_rad,
    output logic signed [31:0]            o_roll_deg,
    output logic signed [31:0]            o_pitch_deg,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ictf_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import ictf_pkg::*;

    t_cfg    r_cfg;
    t_sample w_in, w_smp;
    logic    w_valid, w_take, w_res_valid, w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_gain <= HIGH_GAIN_RST;
            r_cfg.low_gain  <= LOW_GAIN_RST;
            r_cfg.step_gain <= STEP_GAIN_RST;
        end else if (w_wr) begin
            case (paddr)
                ADDR_HIGH_GAIN: r_cfg.high_gain <= pwdata[16:0];
                ADDR_LOW_GAIN:  r_cfg.low_gain  <= pwdata[16:0];
                ADDR_STEP_GAIN: r_cfg.step_gain <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_HIGH_GAIN: prdata = {15'd0, r_cfg.high_gain};
            ADDR_LOW_GAIN:  prdata = {15'd0, r_cfg.low_gain};
            ADDR_STEP_GAIN: prdata = {8'd0, r_cfg.step_gain};
            default:        prdata = 32'd0;
        endcase
    end

    assign w_in = '{gyro_x: i_gyro_x, gyro_y: i_gyro_y, accel_x: i_accel_x,
                    accel_y: i_accel_y, accel_z: i_accel_z};

    ictf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_sample (w_in),
        .o_valid  (w_valid),
        .o_sample (w_smp),
        .i_take   (w_take)
    );

    ictf_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (w_valid),
        .i_sample    (w_smp),
        .o_take      (w_take),
        .o_res_valid (w_res_valid),
        .i_pop       (pop),
        .o_roll_rad  (o_roll_rad),
        .o_pitch_rad (o_pitch_rad),
        .o_roll_deg  (o_roll_deg),
        .o_pitch_deg (o_pitch_deg)
    );

    assign empty = !w_res_valid;

endmodule

// ----- rtl/ictf_checker.sv -----
// port-level checks of the tilt filter, bound to the top level
module ictf_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic        pready,
    input logic [31:0] o_roll_rad,
    input logic [31:0] o_pitch_rad
);

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_rst_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input queue full after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready dropped");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_roll_rad) && $stable(o_pitch_rad)))
        else $error("waiting result changed");

endmodule

bind imu_complementary_tilt_filter ictf_port_checker u_ictf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .pready      (pready),
    .o_roll_rad  (o_roll_rad),
    .o_pitch_rad (o_pitch_rad)
);

// ----- tb/ictf_checker.sv -----
// checker for the tilt filter: predicts each result from accepted samples and compares
`timescale 1ns / 100ps
module ictf_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  logic               full,
    input  logic signed [15:0] i_gyro_x,
    input  logic signed [15:0] i_gyro_y,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic               empty,
    input  logic               pop,
    input  logic signed [31:0] o_roll_rad,
    input  logic signed [31:0] o_pitch_rad,
    input  logic signed [31:0] o_roll_deg,
    input  logic signed [31:0] o_pitch_deg,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ictf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output int                 o_errors,
    output int                 o_pending
);
    import ictf_pkg::*;

    localparam int STEPS = 16;
    localparam logic [31:0] ATAN_TAB [28] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000007};

    typedef struct {
        logic signed [31:0] roll_rad;
        logic signed [31:0] pitch_rad;
        logic signed [31:0] roll_deg;
        logic signed [31:0] pitch_deg;
    } t_angles;

    t_angles angle_q[$];
    t_cfg cfg;
    logic signed [31:0] roll_st, pitch_st;
    int errors;

    assign o_errors = errors;
    assign o_pending = angle_q.size();

    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint root_floor(longint n);
        longint r, b;
        r = 0;
        b = longint'(1) <<< 62;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint tilt_angle(longint num, longint p, longint q);
        longint x, y, z, xs, ys;
        z = 0;
        if (num == 0) return 0;
        x = root_floor((p * p + q * q) <<< 16);
        y = num * 256;
        for (int i = 0; i < STEPS && i < 28; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_TAB[i]);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_TAB[i]);
            end
        end
        return rnd_shift(z, 6);
    endfunction

    function automatic logic signed [31:0] blend_angle(logic signed [31:0] ang, longint rate,
                                                       longint tlt);
        longint inc, sum;
        inc = rnd_shift(rate * longint'(cfg.step_gain), 8);
        sum = longint'(cfg.high_gain) * (longint'(ang) + inc)
            + longint'(cfg.low_gain) * tlt;
        return clip32(rnd_shift(sum, 16));
    endfunction

    function automatic logic signed [31:0] rad_to_deg(logic signed [31:0] ang);
        return clip32(rnd_shift(longint'(ang) * longint'(DEG_PER_RAD), 32));
    endfunction

    always @(posedge i_clk) begin
        t_angles e, a;
        longint rt, pt;
        if (!i_rst_n) begin
            cfg <= '{HIGH_GAIN_RST, LOW_GAIN_RST, STEP_GAIN_RST};
            roll_st <= 0;
            pitch_st <= 0;
            angle_q.delete();
            errors <= 0;
        end else begin
            if (psel && penable && pwrite) begin
                case (paddr)
                    ADDR_HIGH_GAIN: cfg.high_gain <= pwdata[16:0];
                    ADDR_LOW_GAIN:  cfg.low_gain  <= pwdata[16:0];
                    ADDR_STEP_GAIN: cfg.step_gain <= pwdata[23:0];
                    default: ;
                endcase
            end
            if (push && !full) begin
                rt = tilt_angle(i_accel_y, i_accel_x, i_accel_z);
                pt = tilt_angle(i_accel_x, i_accel_y, i_accel_z);
                e.roll_rad = blend_angle(roll_st, i_gyro_x, rt);
                e.pitch_rad = blend_angle(pitch_st, i_gyro_y, pt);
                e.roll_deg = rad_to_deg(e.roll_rad);
                e.pitch_deg = rad_to_deg(e.pitch_rad);
                roll_st <= e.roll_rad;
                pitch_st <= e.pitch_rad;
                angle_q.push_back(e);
            end
            if (pop && !empty) begin
                a = '{o_roll_rad, o_pitch_rad, o_roll_deg, o_pitch_deg};
                if (angle_q.size() == 0) begin
                    if (errors < 10) $display("unexpected result transaction at %0t", $realtime);
                    errors <= errors + 1;
                end else begin
                    e = angle_q.pop_front();
                    if (a != e) begin
                        if (errors < 10)
                            $display("mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                     e.roll_rad, e.pitch_rad, e.roll_deg, e.pitch_deg,
                                     a.roll_rad, a.pitch_rad, a.roll_deg, a.pitch_deg);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- tb/testbench.sv -----
// top of the tilt filter testbench: clock, reset, register writes, samples and verdict
`timescale 1ns / 100ps
module testbench;
    import ictf_pkg::*;

    logic i_clk = 0, i_rst_n = 0;
    logic push = 0, pop = 0;
    logic full, empty, pready;
    logic signed [15:0] gx = 0, gy = 0, ax = 0, ay = 0, az = 0;
    logic signed [31:0] roll_rad, pitch_rad, roll_deg, pitch_deg;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = 0;
    logic [31:0] pwdata = 0, prdata;
    int errors, pending, cycles = 0;
    bit hold_off = 0;

    always #5 i_clk = ~i_clk;

    imu_complementary_tilt_filter uut (
        .i_clk, .i_rst_n, .push, .full,
        .i_gyro_x(gx), .i_gyro_y(gy), .i_accel_x(ax), .i_accel_y(ay), .i_accel_z(az),
        .empty, .pop, .o_roll_rad(roll_rad), .o_pitch_rad(pitch_rad),
        .o_roll_deg(roll_deg), .o_pitch_deg(pitch_deg),
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready);

    ictf_checker chk (
        .i_clk, .i_rst_n, .push, .full,
        .i_gyro_x(gx), .i_gyro_y(gy), .i_accel_x(ax), .i_accel_y(ay), .i_accel_z(az),
        .empty, .pop, .o_roll_rad(roll_rad), .o_pitch_rad(pitch_rad),
        .o_roll_deg(roll_deg), .o_pitch_deg(pitch_deg),
        .psel, .penable, .pwrite, .paddr, .pwdata,
        .o_errors(errors), .o_pending(pending));

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 1500000) begin
            $display("testbench failed");
            $finish;
        end
    end

    // receiver stall pattern, overridden by the long hold-off
    always @(posedge i_clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (hold_off) pop <= 0;
        else if (cycles % 2000 < 600) pop <= 1;
        else pop <= (r < 60);
    end

    task automatic reg_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
        psel <= 1; pwrite <= 1; penable <= 0; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic drain;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic send_sample(logic [15:0] g0, g1, a0, a1, a2);
        push <= 1;
        gx <= g0; gy <= g1; ax <= a0; ay <= a1; az <= a2;
        do @(posedge i_clk); while (full);
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(0, 400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_run(int n);
        int gap, burst;
        while (n > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && n > 0) begin
                // mostly a resting sensor near 1 g with small rates, otherwise extremes, small or random raw values
                if ($urandom_range(0, 3) != 0)
                    send_sample(16'($signed($urandom_range(0, 2000)) - 1000),
                                16'($signed($urandom_range(0, 2000)) - 1000),
                                16'($signed($urandom_range(0, 8000)) - 4000),
                                16'($signed($urandom_range(0, 8000)) - 4000),
                                16'(16384 + $signed($urandom_range(0, 4000)) - 2000));
                else
                    send_sample(pick16(), pick16(), pick16(), pick16(), pick16());
                burst--; n--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
            if (gap != 0) push <= 0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: field extremes and zero numerators, default gains
        send_sample(0, 0, 0, 0, 0);
        send_sample(16'h7FFF, 16'h8000, 0, 16'h7FFF, 16'h8000);
        send_sample(16'h8000, 16'h7FFF, 16'h7FFF, 0, 0);
        send_sample(16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(1, -1, 16'hFFFF, 1, 16384);
        push <= 0;
        drain();
        // gains above one and largest step drive the angles into saturation
        reg_write(ADDR_HIGH_GAIN, 32'h1FFFF);
        reg_write(ADDR_LOW_GAIN, 32'h1FFFF);
        reg_write(ADDR_STEP_GAIN, 32'hFFFFFF);
        repeat (6) send_sample(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1);
        repeat (6) send_sample(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, -1);
        push <= 0;
        drain();
        reg_write(ADDR_HIGH_GAIN, 0);
        reg_write(ADDR_LOW_GAIN, 0);
        reg_write(ADDR_STEP_GAIN, 0);
        send_sample(16'h7FFF, 16'h7FFF, 100, 200, 300);
        push <= 0;
        drain();
        reg_write(ADDR_HIGH_GAIN, 65536);
        reg_write(ADDR_LOW_GAIN, 65536);
        reg_write(ADDR_STEP_GAIN, 1);
        send_sample(500, -500, 1000, -1000, 16000);
        push <= 0;
        drain();
        // back to defaults for the bulk of the run
        reg_write(ADDR_HIGH_GAIN, 32'(HIGH_GAIN_RST));
        reg_write(ADDR_LOW_GAIN, 32'(LOW_GAIN_RST));
        reg_write(ADDR_STEP_GAIN, 32'(STEP_GAIN_RST));
        random_run(300);
        drain();
        // receiver holds off while samples keep coming, so the input stalls
        fork
            begin
                hold_off = 1;
                repeat (1500) @(posedge i_clk);
                hold_off = 0;
            end
            random_run(40);
        join
        drain();
        for (int k = 0; k < 3; k++) begin
            reg_write(ADDR_HIGH_GAIN, $urandom_range(0, 131071));
            reg_write(ADDR_LOW_GAIN, $urandom_range(0, 131071));
            reg_write(ADDR_STEP_GAIN, $urandom_range(0, 16777215));
            random_run(120);
            drain();
        end
        reg_write(ADDR_HIGH_GAIN, 60000);
        reg_write(ADDR_LOW_GAIN, 5536);
        reg_write(ADDR_STEP_GAIN, 20000);
        random_run(350);
        drain();
        if (errors == 0) $display("testbench passed");
        else $display("testbench failed");
        $finish;
    end
endmodule
